// ----- hw/rtl/ppl_pkg.sv -----
// ppl_pkg: shared types and codes for the parity partitioned list
// no dependencies; used by parity_partitioned_list
package ppl_pkg;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SEARCH,
    ST_SHIFT,
    ST_FINISH
  } state_t;

endpackage

// ----- hw/rtl/ppl_ram.sv -----
// ppl_ram: generic single write port, single read port ram
// registered read data; no dependencies
module ppl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/parity_partitioned_list.sv -----
// parity_partitioned_list: ordered list of signed words held in a circular ram
// each word passes ST_EXEC then ST_FINISH; read adds ST_RDWAIT, and remove adds one
// ST_SEARCH step per entry searched and one ST_SHIFT step per entry moved; the ram read port sets the pace
// one word at a time, the next word taken only once the last result is registered;
// a new word is taken while the last result waits on out_ready; reset (sync, active high)
// clears count, head and handshake, storage is not cleared; depends on ppl_pkg, ppl_ram
module parity_partitioned_list #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ppl_pkg::ACTION_W-1:0]      action,
  input  logic signed [ppl_pkg::VALUE_W-1:0] value,
  input  logic [ppl_pkg::POS_W-1:0]         position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ppl_pkg::STATUS_W-1:0]      status,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count,
  output logic signed [ppl_pkg::VALUE_W-1:0] read_value
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int OW   = AW + 1;
  localparam int CMPW = (ppl_pkg::POS_W > OW) ? ppl_pkg::POS_W : OW;
  localparam int VW   = ppl_pkg::VALUE_W;

  ppl_pkg::state_t state, state_next;

  // control registers
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] idx, idx_next;

  // latched word and result
  logic [ppl_pkg::ACTION_W-1:0] act_r;
  logic [VW-1:0]                val_r;
  logic [ppl_pkg::POS_W-1:0]    pos_r;
  logic [ppl_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [VW-1:0]                res_value, res_value_next;

  // ram port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] ram_wdata, ram_rdata;

  // circular address: base plus offset, offset at most DEPTH
  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                              input logic [OW-1:0] off);
    logic [OW:0] sum;
    sum = (OW+1)'(base) + (OW+1)'(off);
    if (sum >= (OW+1)'(DEPTH)) begin
      sum = sum - (OW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // shared conditions
  logic [OW-1:0]   count_o, idx_p1;
  logic [CMPW-1:0] pos_ext, count_ext;
  logic [AW-1:0]   head_dec;
  logic            is_full, is_empty, is_odd, pos_ok, hit, last;

  assign count_o   = OW'(count);
  assign idx_p1    = OW'(idx) + OW'(1);
  assign pos_ext   = CMPW'(pos_r);
  assign count_ext = CMPW'(count);
  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign is_odd    = val_r[0];
  assign pos_ok    = (pos_ext < count_ext);
  assign hit       = (ram_rdata == val_r);
  assign last      = (idx_p1 == count_o);

  assign in_ready = (state == ppl_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ppl_pkg::ST_IDLE: begin
        if (in_valid) state_next = ppl_pkg::ST_EXEC;
      end
      ppl_pkg::ST_EXEC: begin
        case (act_r)
          ppl_pkg::ACT_REMOVE: begin
            state_next = is_empty ? ppl_pkg::ST_FINISH : ppl_pkg::ST_SEARCH;
          end
          ppl_pkg::ACT_READ: begin
            state_next = pos_ok ? ppl_pkg::ST_RDWAIT : ppl_pkg::ST_FINISH;
          end
          default: state_next = ppl_pkg::ST_FINISH;
        endcase
      end
      ppl_pkg::ST_RDWAIT: state_next = ppl_pkg::ST_FINISH;
      ppl_pkg::ST_SEARCH: begin
        if (last) state_next = ppl_pkg::ST_FINISH;
        else if (hit) state_next = ppl_pkg::ST_SHIFT;
      end
      ppl_pkg::ST_SHIFT: begin
        if (last) state_next = ppl_pkg::ST_FINISH;
      end
      ppl_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ppl_pkg::ST_IDLE;
      end
      default: state_next = ppl_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = val_r;
    ram_re          = 1'b0;
    ram_raddr       = wrap_addr(head, idx_p1);
    count_next      = count;
    head_next       = head;
    idx_next        = idx;
    res_status_next = res_status;
    res_value_next  = res_value;
    case (state)
      ppl_pkg::ST_EXEC: begin
        res_status_next = ppl_pkg::STATUS_OK;
        res_value_next  = '0;
        idx_next        = '0;
        case (act_r)
          ppl_pkg::ACT_INSERT: begin
            if (is_full) begin
              res_status_next = ppl_pkg::STATUS_FULL;
            end else begin
              // odd goes to the front, even to the back
              ram_we     = 1'b1;
              count_next = count + CW'(1);
              if (is_odd) begin
                ram_waddr = head_dec;
                head_next = head_dec;
              end else begin
                ram_waddr = wrap_addr(head, count_o);
              end
            end
          end
          ppl_pkg::ACT_REMOVE: begin
            if (is_empty) begin
              res_status_next = ppl_pkg::STATUS_MISSING;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head;
            end
          end
          ppl_pkg::ACT_READ: begin
            if (pos_ok) begin
              ram_re    = 1'b1;
              ram_raddr = wrap_addr(head, pos_ext[OW-1:0]);
            end else begin
              res_status_next = ppl_pkg::STATUS_BAD_POS;
            end
          end
          default: ;
        endcase
      end
      ppl_pkg::ST_RDWAIT: begin
        res_value_next = ram_rdata;
      end
      ppl_pkg::ST_SEARCH: begin
        // compare entry idx, prefetch idx+1
        ram_re   = 1'b1;
        idx_next = idx_p1[AW-1:0];
        if (hit) begin
          if (last) count_next = count - CW'(1);
        end else if (last) begin
          res_status_next = ppl_pkg::STATUS_MISSING;
        end
      end
      ppl_pkg::ST_SHIFT: begin
        // move entry idx down to idx-1, prefetch idx+1
        ram_we    = 1'b1;
        ram_waddr = wrap_addr(head, OW'(idx - AW'(1)));
        ram_wdata = ram_rdata;
        ram_re    = 1'b1;
        idx_next  = idx_p1[AW-1:0];
        if (last) count_next = count - CW'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ppl_pkg::ST_IDLE;
      count     <= '0;
      head      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      idx   <= idx_next;
      if (state == ppl_pkg::ST_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ppl_pkg::ST_IDLE && in_valid) begin
      act_r <= action;
      val_r <= $unsigned(value);
      pos_r <= position;
    end
    res_status <= res_status_next;
    res_value  <= res_value_next;
    if (state == ppl_pkg::ST_FINISH && (!out_valid || out_ready)) begin
      status      <= res_status;
      entry_count <= count;
      read_value  <= $signed(res_value);
    end
  end

  // entry storage
  ppl_ram #(
    .WIDTH(VW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
